@@ hw/rtl/mmcs_pkg.sv @@
// mmcs_pkg: shared types and constants for the min/max contrast stretch block
// used by the front, queue, back and top level files; no dependencies
package mmcs_pkg;

   localparam int PIX_W          = 8;
   localparam int STEP_W         = $clog2(PIX_W);
   localparam int NUM_W          = PIX_W + 9;      // 510*d + range
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic FUNC_MEASURE = 1'b0;
   localparam logic FUNC_MAP     = 1'b1;

   localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
   localparam logic [PIX_W-1:0] PIX_MIN = '0;

   // one classified map transaction
   typedef struct packed {
      logic             flat;
      logic             below;
      logic             above;
      logic [PIX_W-1:0] pixel;
      logic [PIX_W-1:0] delta;
      logic [PIX_W-1:0] span;
   } mmcs_item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } mmcs_qstat_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } mmcs_state_type;

endpackage

@@ hw/rtl/mmcs_front.sv @@
// mmcs_front: accepts transactions, tracks min/max, classifies map bytes
// depends on mmcs_pkg
module mmcs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic                          req_start_frame,
   input  logic [mmcs_pkg::PIX_W-1:0]    req_pixel_value,
   input  mmcs_pkg::mmcs_qstat_type      qstat,
   output logic                          push,
   output mmcs_pkg::mmcs_item_type       push_item
);
   import mmcs_pkg::*;

   logic [PIX_W-1:0] low_ff, low_in;
   logic [PIX_W-1:0] high_ff, high_in;
   logic             accept;
   logic [PIX_W-1:0] delta;
   logic [PIX_W-1:0] span;

   // only map bytes need a queue slot
   assign req_stall = qstat.full && (req_func == FUNC_MAP);
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_func == FUNC_MAP);

   assign delta = req_pixel_value - low_ff;
   assign span  = high_ff - low_ff;

   always_comb begin
      push_item       = '0;
      push_item.flat  = high_ff <= low_ff;
      push_item.below = req_pixel_value < low_ff;
      push_item.above = delta >= span;
      push_item.pixel = req_pixel_value;
      push_item.delta = delta;
      push_item.span  = span;
   end

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (accept && (req_func == FUNC_MEASURE)) begin
         if (req_start_frame) begin
            low_in  = req_pixel_value;
            high_in = req_pixel_value;
         end else begin
            if (req_pixel_value < low_ff) begin
               low_in = req_pixel_value;
            end
            if (req_pixel_value > high_ff) begin
               high_in = req_pixel_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= PIX_MAX;
         high_ff <= PIX_MIN;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

endmodule

@@ hw/rtl/mmcs_queue.sv @@
// mmcs_queue: short fifo of classified map transactions between front and back
// depends on mmcs_pkg
module mmcs_queue #(
   parameter int QUEUE_DEPTH = mmcs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mmcs_pkg::mmcs_item_type  push_item,
   input  logic                     pop,
   output mmcs_pkg::mmcs_item_type  head_item,
   output mmcs_pkg::mmcs_qstat_type qstat
);
   import mmcs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   mmcs_item_type    mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign qstat.full  = count_ff == FULL_CNT;
   assign qstat.empty = count_ff == '0;
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/mmcs_back.sv @@
// mmcs_back: restoring divider that stretches one queued byte, plus output register
// depends on mmcs_pkg
module mmcs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  mmcs_pkg::mmcs_qstat_type     qstat,
   input  mmcs_pkg::mmcs_item_type      head_item,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mmcs_pkg::PIX_W-1:0]   rsp_scaled_value,
   output logic                         rsp_flat_range
);
   import mmcs_pkg::*;

   localparam int DSH_W = 2 * PIX_W;

   mmcs_state_type   state_ff, state_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0] dsh_ff, dsh_in;
   logic [PIX_W-1:0] quo_ff, quo_in;
   logic             flat_ff, flat_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_value_ff, out_value_in;
   logic             out_flat_ff, out_flat_in;
   logic [NUM_W-1:0] numer;
   logic [NUM_W-1:0] dsh_ext;
   logic             fits;
   logic             slot_free;
   logic             load_out;

   // 510*d + range as shift and subtract
   assign numer = {head_item.delta, 9'b0} - {8'b0, head_item.delta, 1'b0}
                  + {9'b0, head_item.span};
   assign dsh_ext   = {{(NUM_W-DSH_W){1'b0}}, dsh_ff};
   assign fits      = rem_ff >= dsh_ext;
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == ST_FIN) && slot_free;
   assign pop       = (state_ff == ST_IDLE) && !qstat.empty;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      flat_in  = flat_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               flat_in  = head_item.flat;
               state_in = ST_FIN;
               if (head_item.flat) begin
                  quo_in = head_item.pixel;
               end else if (head_item.below) begin
                  quo_in = PIX_MIN;
               end else if (head_item.above) begin
                  quo_in = PIX_MAX;
               end else begin
                  // divisor 2*range aligned to the top quotient bit
                  rem_in   = numer;
                  dsh_in   = {head_item.span, {PIX_W{1'b0}}};
                  quo_in   = '0;
                  step_in  = STEP_W'(PIX_W - 1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (fits) begin
               rem_in = rem_ff - dsh_ext;
            end
            quo_in  = {quo_ff[PIX_W-2:0], fits};
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_flat_in  = out_flat_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_value_in = quo_ff;
         out_flat_in  = flat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      flat_ff      <= flat_in;
      step_ff      <= step_in;
      out_value_ff <= out_value_in;
      out_flat_ff  <= out_flat_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_scaled_value = out_value_ff;
   assign rsp_flat_range   = out_flat_ff;

endmodule

@@ hw/rtl/min_max_contrast_stretch.sv @@
// min_max_contrast_stretch: top level of the two-pass min/max contrast stretch
// depends on mmcs_pkg, mmcs_front, mmcs_queue, mmcs_back
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | func, start_frame, pixel_value
//   rsp_    | out       | rsp_valid/rsp_stall  | scaled_value, flat_range
//
// measure transactions are never stalled and give no response
// a map transaction that needs the divider goes through one load, eight restoring steps and
// one hand-off in the back end; a flat or clamped one goes from the load to the hand-off
// the front keeps accepting while the queue has room; map bytes stall when it is full
// reset (synchronous, active high) sets min to 255 and max to 0 and empties the queue
// a response waiting on rsp_stall holds the back end after its next result only
module min_max_contrast_stretch #(
   parameter int QUEUE_DEPTH = mmcs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic                        req_start_frame,
   input  logic [mmcs_pkg::PIX_W-1:0]  req_pixel_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mmcs_pkg::PIX_W-1:0]  rsp_scaled_value,
   output logic                        rsp_flat_range
);
   import mmcs_pkg::*;

   mmcs_qstat_type qstat;
   mmcs_item_type  push_item;
   mmcs_item_type  head_item;
   logic           push;
   logic           pop;

   // front: min/max tracking, classification snapshot for map bytes
   mmcs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_start_frame (req_start_frame),
      .req_pixel_value (req_pixel_value),
      .qstat           (qstat),
      .push            (push),
      .push_item       (push_item)
   );

   // decoupling queue
   mmcs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // back: divider and output register
   mmcs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .qstat            (qstat),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_flat_range   (rsp_flat_range)
   );

endmodule

@@ hw/rtl/mmcs_checker.sv @@
// mmcs_checker: port-level checks for min_max_contrast_stretch, with its bind
// depends on mmcs_pkg
module mmcs_checker #(
   parameter int QUEUE_DEPTH = mmcs_pkg::QUEUE_DEPTH_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_func,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [mmcs_pkg::PIX_W-1:0]  rsp_scaled_value,
   input logic                        rsp_flat_range
);
   import mmcs_pkg::*;

   localparam int MAX_OPEN = QUEUE_DEPTH + 2;
   localparam int OPEN_W   = $clog2(MAX_OPEN + 2) + 1;

   logic [OPEN_W-1:0] open_ff, open_in;
   logic              map_acc;
   logic              rsp_acc;

   assign map_acc = req_valid && !req_stall && (req_func == FUNC_MAP);
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_comb begin
      open_in = open_ff;
      if (map_acc && !rsp_acc) begin
         open_in = open_ff + 1'b1;
      end else if (rsp_acc && !map_acc) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // no response without an outstanding map transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != '0)
      else $error("response without outstanding map transaction");

   // outstanding work never exceeds queue plus back end plus output register
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= OPEN_W'(MAX_OPEN))
      else $error("too many outstanding map transactions");

   // a held response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scaled_value)
                                 && $stable(rsp_flat_range))
      else $error("stalled response changed");

   // response channel is quiet right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind min_max_contrast_stretch mmcs_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mmcs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_scaled_value (rsp_scaled_value),
   .rsp_flat_range   (rsp_flat_range)
);
